// ----- design/pad_pkg.sv -----
package pad_pkg;

   localparam int ANGLE_FRAC   = 24;
   localparam int CORDIC_STEPS = 26;
   localparam int CORDIC_WIDTH = 64;
   localparam int Z_WIDTH      = 32;
   localparam int ANG_WIDTH    = 33;
   localparam int QUEUE_DEPTH  = 4;

   // angles in degrees with ANGLE_FRAC fractional bits
   localparam logic signed [Z_WIDTH-1:0] Z_DEG_90 = Z_WIDTH'(64'd90 << ANGLE_FRAC);
   localparam logic [ANG_WIDTH-1:0] DEG_90  = ANG_WIDTH'(64'd90 << ANGLE_FRAC);
   localparam logic [ANG_WIDTH-1:0] DEG_180 = ANG_WIDTH'(64'd180 << ANGLE_FRAC);
   localparam logic [ANG_WIDTH-1:0] DEG_270 = ANG_WIDTH'(64'd270 << ANGLE_FRAC);
   localparam logic [ANG_WIDTH-1:0] DEG_360 = ANG_WIDTH'(64'd360 << ANGLE_FRAC);

   typedef enum logic [2:0] {
      CLS_Q1,
      CLS_Q2,
      CLS_Q3,
      CLS_Q4,
      CLS_POS_Y,
      CLS_NEG_Y,
      CLS_ORIGIN
   } cls_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // atan(2^-step) in degrees, ANGLE_FRAC fractional bits
   function automatic logic [Z_WIDTH-1:0] atan_deg(input int step);
      case (step)
         0:  return 32'd754974720;
         1:  return 32'd445687602;
         2:  return 32'd235489088;
         3:  return 32'd119537938;
         4:  return 32'd60000934;
         5:  return 32'd30029717;
         6:  return 32'd15018523;
         7:  return 32'd7509720;
         8:  return 32'd3754917;
         9:  return 32'd1877466;
         10: return 32'd938734;
         11: return 32'd469367;
         12: return 32'd234684;
         13: return 32'd117342;
         14: return 32'd58671;
         15: return 32'd29335;
         16: return 32'd14668;
         17: return 32'd7334;
         18: return 32'd3667;
         19: return 32'd1833;
         20: return 32'd917;
         21: return 32'd458;
         22: return 32'd229;
         23: return 32'd115;
         24: return 32'd57;
         25: return 32'd29;
         default: return '0;
      endcase
   endfunction

endpackage

// ----- design/pad_req_if.sv -----
interface pad_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

// ----- design/pad_rsp_if.sv -----
interface pad_rsp_if #(parameter int FRACTION_BITS = 8);
   logic                       valid;
   logic                       ready;
   logic [9+FRACTION_BITS-1:0] angle_deg;

   modport source (output valid, output angle_deg, input ready);
   modport sink (input valid, input angle_deg, output ready);
endinterface

// ----- design/pad_front.sv -----
module pad_front #(
   parameter int COORD_WIDTH = 16,
   parameter int ENTRY_WIDTH = 35
) (
   input  logic                   clock,
   input  logic                   reset,
   pad_req_if.sink                req_chan,
   input  pad_pkg::q_stat_type    q_stat,
   output logic                   q_push,
   output logic [ENTRY_WIDTH-1:0] q_push_data
);
   import pad_pkg::*;

   logic signed [COORD_WIDTH-1:0] x;
   logic signed [COORD_WIDTH-1:0] y;
   logic [COORD_WIDTH-1:0]        ax;
   logic [COORD_WIDTH-1:0]        ay;
   cls_type                       cls;
   logic                          x_zero;
   logic                          y_zero;
   logic                          x_neg;
   logic                          y_neg;
   logic                          reset_seen_ff;

   // hold off requests during reset
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_seen_ff <= 1'b0;
      end else begin
         reset_seen_ff <= 1'b1;
      end
   end

   assign x = req_chan.x_coord;
   assign y = req_chan.y_coord;
   assign x_zero = (x == '0);
   assign y_zero = (y == '0);
   assign x_neg  = x[COORD_WIDTH-1];
   assign y_neg  = y[COORD_WIDTH-1];

   // magnitude of the most negative value still fits unsigned
   assign ax = x_neg ? (~$unsigned(x) + COORD_WIDTH'(1)) : $unsigned(x);
   assign ay = y_neg ? (~$unsigned(y) + COORD_WIDTH'(1)) : $unsigned(y);

   always_comb begin
      if (x_zero) begin
         if (y_zero) begin
            cls = CLS_ORIGIN;
         end else if (y_neg) begin
            cls = CLS_NEG_Y;
         end else begin
            cls = CLS_POS_Y;
         end
      end else if (!x_neg && !y_neg) begin
         cls = CLS_Q1;
      end else if (x_neg && !y_neg) begin
         cls = CLS_Q2;
      end else if (x_neg) begin
         cls = CLS_Q3;
      end else begin
         cls = CLS_Q4;
      end
   end

   assign req_chan.ready = reset_seen_ff && !q_stat.full;
   assign q_push         = req_chan.valid && req_chan.ready;
   assign q_push_data    = {cls, ax, ay};

endmodule

// ----- design/pad_queue.sv -----
module pad_queue #(
   parameter int WIDTH = 35
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [WIDTH-1:0]    push_data,
   input  logic                pop,
   output logic [WIDTH-1:0]    pop_data,
   output pad_pkg::q_stat_type stat
);
   import pad_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff;
   logic [PTR_W-1:0] rd_ff;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W-1:0] wr_in;
   logic [PTR_W-1:0] rd_in;

   assign wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
   assign rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_in;
         end
         if (pop) begin
            rd_ff <= rd_in;
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data   = slot_ff[rd_ff];
   assign stat.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

// ----- design/pad_back.sv -----
module pad_back #(
   parameter int COORD_WIDTH   = 16,
   parameter int FRACTION_BITS = 8,
   parameter int ENTRY_WIDTH   = 35
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  logic [ENTRY_WIDTH-1:0] q_data,
   output logic                   q_pop,
   pad_rsp_if.source              rsp_chan
);
   import pad_pkg::*;

   localparam int OUT_W      = 9 + FRACTION_BITS;
   localparam int LOAD_SHIFT = CORDIC_WIDTH - 2 - COORD_WIDTH;
   localparam int RSHIFT     = ANGLE_FRAC - FRACTION_BITS;
   localparam int CLS_W      = $bits(cls_type);
   localparam logic [ANG_WIDTH:0] HALF = (ANG_WIDTH+1)'(1) << (RSHIFT - 1);
   localparam logic [ANG_WIDTH:0] WRAP = (ANG_WIDTH+1)'(360) << FRACTION_BITS;

   logic signed [CORDIC_WIDTH-1:0] cx_ff  [CORDIC_STEPS+1];
   logic signed [CORDIC_WIDTH-1:0] cy_ff  [CORDIC_STEPS+1];
   logic signed [Z_WIDTH-1:0]      z_ff   [CORDIC_STEPS+1];
   cls_type                        cls_ff [CORDIC_STEPS+1];
   logic [CORDIC_STEPS:0]          v_ff;

   logic                 advance;
   logic [COORD_WIDTH-1:0] q_ax;
   logic [COORD_WIDTH-1:0] q_ay;
   cls_type              q_cls;

   logic                 u_valid_ff;
   logic [ANG_WIDTH-1:0] ang_ff;
   logic [ANG_WIDTH-1:0] ang_in;
   logic [ANG_WIDTH-1:0] theta;
   logic signed [Z_WIDTH-1:0] z_last;

   logic                 out_valid_ff;
   logic [OUT_W-1:0]     angle_ff;
   logic [OUT_W-1:0]     angle_in;
   logic [ANG_WIDTH:0]   rounded;

   // whole back end moves together whenever the output register can take a result
   assign advance = !out_valid_ff || rsp_chan.ready;
   assign q_pop   = advance && q_valid;

   assign q_cls = cls_type'(q_data[ENTRY_WIDTH-1 -: CLS_W]);
   assign q_ax  = q_data[2*COORD_WIDTH-1:COORD_WIDTH];
   assign q_ay  = q_data[COORD_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         u_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v_ff         <= {v_ff[CORDIC_STEPS-1:0], q_valid};
         u_valid_ff   <= v_ff[CORDIC_STEPS];
         out_valid_ff <= u_valid_ff;
      end
   end

   // load: folded point scaled to the top of the datapath
   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff[0]  <= $signed({2'b00, q_ax, {LOAD_SHIFT{1'b0}}});
         cy_ff[0]  <= $signed({2'b00, q_ay, {LOAD_SHIFT{1'b0}}});
         z_ff[0]   <= '0;
         cls_ff[0] <= q_cls;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      localparam logic signed [Z_WIDTH-1:0] ATAN = $signed(atan_deg(i));
      logic signed [CORDIC_WIDTH-1:0] dx;
      logic signed [CORDIC_WIDTH-1:0] dy;

      // arithmetic shift floors, as each micro-rotation needs
      assign dx = cy_ff[i] >>> i;
      assign dy = cx_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (advance) begin
            if (!cy_ff[i][CORDIC_WIDTH-1]) begin
               cx_ff[i+1] <= cx_ff[i] + dx;
               cy_ff[i+1] <= cy_ff[i] - dy;
               z_ff[i+1]  <= z_ff[i] + ATAN;
            end else begin
               cx_ff[i+1] <= cx_ff[i] - dx;
               cy_ff[i+1] <= cy_ff[i] + dy;
               z_ff[i+1]  <= z_ff[i] - ATAN;
            end
            cls_ff[i+1] <= cls_ff[i];
         end
      end
   end

   // clamp the folded angle to [0, 90] and unfold by quadrant
   assign z_last = z_ff[CORDIC_STEPS];

   always_comb begin
      if (z_last[Z_WIDTH-1]) begin
         theta = '0;
      end else if (z_last > Z_DEG_90) begin
         theta = DEG_90;
      end else begin
         theta = ANG_WIDTH'(z_last);
      end
   end

   always_comb begin
      unique case (cls_ff[CORDIC_STEPS])
         CLS_Q1:     ang_in = theta;
         CLS_Q2:     ang_in = DEG_180 - theta;
         CLS_Q3:     ang_in = DEG_180 + theta;
         CLS_Q4:     ang_in = DEG_360 - theta;
         CLS_POS_Y:  ang_in = DEG_90;
         CLS_NEG_Y:  ang_in = DEG_270;
         CLS_ORIGIN: ang_in = '0;
         default:    ang_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ang_ff <= ang_in;
      end
   end

   // round half up, then wrap a full turn to zero
   assign rounded  = ({1'b0, ang_ff} + HALF) >> RSHIFT;
   assign angle_in = (rounded >= WRAP) ? '0 : rounded[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.angle_deg = angle_ff;

endmodule

// ----- design/point_angle_degrees_core.sv -----
// Polar angle of a signed integer point (x, y) in degrees, counter-clockwise
// from the positive x axis, in [0, 360) with FRACTION_BITS fractional bits,
// rounded and within two LSB. Points on the y axis give exactly 90 or 270, the
// origin gives 0. One request is taken per clock while the front queue is not
// full, and results come back in request order. A request passes from the
// front queue through a load stage, 26 unrolled CORDIC vectoring stages, an
// unfold stage and the output register; the sustained rate is one request
// per cycle while the result side is ready, set by the unrolled 26-stage
// CORDIC pipeline. While a result is not taken the back end holds, and the
// four-entry front queue keeps taking requests until it fills.
module point_angle_degrees_core #(
   parameter int COORD_WIDTH   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   pad_req_if.sink   req_chan,
   pad_rsp_if.source rsp_chan
);
   import pad_pkg::*;

   localparam int ENTRY_WIDTH = $bits(cls_type) + 2 * COORD_WIDTH;

   logic                   q_push;
   logic [ENTRY_WIDTH-1:0] q_push_data;
   logic                   q_pop;
   logic [ENTRY_WIDTH-1:0] q_pop_data;
   q_stat_type             q_stat;

   pad_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   pad_queue #(
      .WIDTH (ENTRY_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   pad_back #(
      .COORD_WIDTH   (COORD_WIDTH),
      .FRACTION_BITS (FRACTION_BITS),
      .ENTRY_WIDTH   (ENTRY_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (!q_stat.empty),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- tb/testbench.sv -----
module testbench;
   import pad_pkg::*;

   localparam int COORD_W     = 16;
   localparam int FRAC_BITS   = 8;
   localparam int ANGLE_BITS  = 9 + FRAC_BITS;
   localparam int ACC_FRAC    = 24;
   localparam int STAGES      = 26;
   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_TAIL  = 100;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AFTER  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT = 2000;

   localparam longint DEG_90  = 90;
   localparam longint DEG_180 = 180;
   localparam longint DEG_270 = 270;
   localparam longint DEG_360 = 360;

   // atan(2^-i) in degrees, 24 fractional bits
   localparam longint ATAN_STEP [STAGES] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115, 57, 29
   };

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   logic clock = 1'b0;
   logic reset;

   pad_req_if #(.COORD_WIDTH(COORD_W)) req_chan ();
   pad_rsp_if #(.FRACTION_BITS(FRAC_BITS)) rsp_chan ();

   point_angle_degrees_core #(
      .COORD_WIDTH(COORD_W),
      .FRACTION_BITS(FRAC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   point_type             pending_points[$];
   logic [ANGLE_BITS-1:0] expected_angles[$];
   point_type             next_point;
   int                    failures = 0;
   int                    requests_taken = 0;
   int                    angles_seen = 0;
   int                    send_gap = 0;
   int                    stall_left = 0;
   int                    hold_left = 0;
   bit                    hold_done = 1'b0;
   int                    quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // polar angle in degrees with FRAC_BITS fractional bits
   function automatic logic [ANGLE_BITS-1:0] polar_angle(point_type pt);
      longint ax, ay, cx, cy, dx, dy, z, ang, rounded;
      if (pt.x == 0) begin
         if (pt.y > 0)
            return ANGLE_BITS'(DEG_90 << FRAC_BITS);
         else if (pt.y < 0)
            return ANGLE_BITS'(DEG_270 << FRAC_BITS);
         return '0;
      end
      ax = (pt.x < 0) ? -longint'(pt.x) : longint'(pt.x);
      ay = (pt.y < 0) ? -longint'(pt.y) : longint'(pt.y);
      cx = ax << (62 - COORD_W);
      cy = ay << (62 - COORD_W);
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy >= 0) begin
            cx = cx + dx;
            cy = cy - dy;
            z = z + ATAN_STEP[i];
         end else begin
            cx = cx - dx;
            cy = cy + dy;
            z = z - ATAN_STEP[i];
         end
      end
      if (z < 0)
         z = 0;
      if (z > (DEG_90 << ACC_FRAC))
         z = DEG_90 << ACC_FRAC;
      // unfold from the first quadrant
      if (pt.x > 0 && pt.y >= 0)
         ang = z;
      else if (pt.x < 0 && pt.y >= 0)
         ang = (DEG_180 << ACC_FRAC) - z;
      else if (pt.x < 0)
         ang = (DEG_180 << ACC_FRAC) + z;
      else
         ang = (DEG_360 << ACC_FRAC) - z;
      rounded = (ang + (longint'(1) << (ACC_FRAC - 1 - FRAC_BITS))) >>> (ACC_FRAC - FRAC_BITS);
      if (rounded >= (DEG_360 << FRAC_BITS))
         rounded = 0;
      return ANGLE_BITS'(rounded);
   endfunction

   function automatic point_type make_point(int x, int y);
      point_type pt;
      pt.x = COORD_W'(x);
      pt.y = COORD_W'(y);
      return pt;
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return -32767;
         2: return -1;
         3: return 0;
         4: return 1;
         default: return 32767;
      endcase
   endfunction

   function automatic point_type random_point();
      int mag;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         return make_point($urandom_range(0, 65535), $urandom_range(0, 65535));
      if (pick < 60)
         return make_point($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
      if (pick < 70) begin
         // on or next to an axis
         mag = $urandom_range(0, 65535);
         case ($urandom_range(0, 3))
            0: return make_point(0, mag);
            1: return make_point(mag, 0);
            2: return make_point($urandom_range(0, 2) - 1, mag);
            default: return make_point(mag, $urandom_range(0, 2) - 1);
         endcase
      end
      if (pick < 85) begin
         mag = $urandom_range(1, 32767);
         return make_point($urandom_range(0, 1) ? mag : -mag, $urandom_range(0, 1) ? mag : -mag);
      end
      return make_point(pick_extreme(), pick_extreme());
   endfunction

   // stretches of the run where both sides may idle
   function automatic bit idling_allowed(int count);
      return (pending_points.size() > QUIET_TAIL) && ((count % 300) < 200);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            next_point.x = req_chan.x_coord;
            next_point.y = req_chan.y_coord;
            expected_angles.push_back(polar_angle(next_point));
            requests_taken <= requests_taken + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               req_chan.valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_points.size() > 0) begin
               next_point = pending_points.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.x_coord <= next_point.x;
               req_chan.y_coord <= next_point.y;
               if (idling_allowed(requests_taken) && $urandom_range(0, 7) == 0)
                  send_gap <= $urandom_range(1, 10);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            angles_seen <= angles_seen + 1;
            if (expected_angles.size() == 0) begin
               $error("angle_deg: unexpected result %0d", rsp_chan.angle_deg);
               failures++;
            end else if (rsp_chan.angle_deg !== expected_angles[0]) begin
               $error("angle_deg mismatch: expected %0d, actual %0d",
                      expected_angles[0], rsp_chan.angle_deg);
               failures++;
               void'(expected_angles.pop_front());
            end else begin
               void'(expected_angles.pop_front());
            end
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_done && requests_taken >= HOLD_AFTER) begin
            // long hold so the pipeline and front queue fill up
            rsp_chan.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (idling_allowed(angles_seen) && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.x_coord = '0;
      req_chan.y_coord = '0;
      rsp_chan.ready = 1'b0;

      // directed points: origin, axes, extremes, diagonals, wrap to zero
      pending_points.push_back(make_point(0, 0));
      pending_points.push_back(make_point(0, 1));
      pending_points.push_back(make_point(0, -1));
      pending_points.push_back(make_point(0, 32767));
      pending_points.push_back(make_point(0, -32768));
      pending_points.push_back(make_point(1, 0));
      pending_points.push_back(make_point(32767, 0));
      pending_points.push_back(make_point(-1, 0));
      pending_points.push_back(make_point(-32768, 0));
      pending_points.push_back(make_point(32767, 32767));
      pending_points.push_back(make_point(-32768, 32767));
      pending_points.push_back(make_point(-32768, -32768));
      pending_points.push_back(make_point(32767, -32768));
      pending_points.push_back(make_point(1, 1));
      pending_points.push_back(make_point(-1, 1));
      pending_points.push_back(make_point(-1, -1));
      pending_points.push_back(make_point(1, -1));
      pending_points.push_back(make_point(32767, -1));
      pending_points.push_back(make_point(32767, 1));
      pending_points.push_back(make_point(-32768, -1));
      pending_points.push_back(make_point(-32768, 1));
      pending_points.push_back(make_point(1, 32767));
      pending_points.push_back(make_point(1, -32768));
      pending_points.push_back(make_point(-1, -32768));
      for (int i = 0; i < RANDOM_ITEMS; i++)
         pending_points.push_back(random_point());

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_points.size() != 0 || req_chan.valid || expected_angles.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- point_angle_degrees_core.f -----
design/pad_pkg.sv
design/pad_req_if.sv
design/pad_rsp_if.sv
design/pad_front.sv
design/pad_queue.sv
design/pad_back.sv
design/point_angle_degrees_core.sv
tb/testbench.sv
